// File: hdl/message_frame_deframer_top_macros.svh
// Assertion macros used by the checker file.
`ifndef MESSAGE_FRAME_DEFRAMER_TOP_MACROS_SVH
`define MESSAGE_FRAME_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define MFD_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define MFD_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/mfd_pkg.sv
`timescale 1ns / 1ps

package mfd_pkg;

   localparam int HDR_BYTES  = 12;
   localparam int CNT_W      = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   localparam logic [1:0] ERR_MAGIC   = 2'd0;
   localparam logic [1:0] ERR_VERSION = 2'd1;
   localparam logic [1:0] ERR_LENGTH  = 2'd2;

   localparam logic REG_MAGIC   = 1'b0;
   localparam logic REG_VERSION = 1'b1;

   typedef struct packed {
      logic [15:0] magic;
      logic [7:0]  version;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [7:0]  message_type;
      logic [15:0] status_code;
      logic [31:0] sequence_res;
      logic [15:0] payload_length;
      logic [7:0]  payload_byte;
      logic        last;
      logic [1:0]  error_kind;
   } rsp_type;

endpackage

// File: hdl/mfd_csr.sv
`timescale 1ns / 1ps

module mfd_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [mfd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [mfd_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [mfd_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output mfd_pkg::cfg_type               cfg
);
   import mfd_pkg::*;

   logic        reg_idx;
   logic        wr_en;
   logic [15:0] magic_ff, magic_in;
   logic [7:0]  version_ff, version_in;

   assign reg_idx = paddr[2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      magic_in   = magic_ff;
      version_in = version_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_MAGIC:   magic_in   = pwdata[15:0];
            REG_VERSION: version_in = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_MAGIC:   prdata = {{(CSR_DATA_W-16){1'b0}}, magic_ff};
         REG_VERSION: prdata = {{(CSR_DATA_W-8){1'b0}}, version_ff};
         default:     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff   <= '0;
         version_ff <= '0;
      end else begin
         magic_ff   <= magic_in;
         version_ff <= version_in;
      end
   end

   assign cfg.magic   = magic_ff;
   assign cfg.version = version_ff;

endmodule

// File: hdl/mfd_core.sv
`timescale 1ns / 1ps

module mfd_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       stream_byte,
   input  mfd_pkg::cfg_type cfg,
   output mfd_pkg::rsp_type res
);
   import mfd_pkg::*;

   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_PAYLOAD = 2'd1;
   localparam logic [1:0] PH_DEAD    = 2'd2;

   localparam int HIST_W = 8 * (HDR_BYTES - 1);
   localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(HDR_BYTES - 1);
   localparam logic [15:0] HDR_LEN = 16'(HDR_BYTES);

   logic [1:0]       phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [15:0]      remain_ff, remain_in;
   logic [HIST_W-1:0] hist_ff, hist_in;

   logic [8*HDR_BYTES-1:0] full;
   logic [15:0] magic, total, remain_dec;
   logic [7:0]  version;

   assign full       = {hist_ff, stream_byte};
   assign magic      = full[95:80];
   assign version    = full[79:72];
   assign total      = full[63:48];
   assign remain_dec = remain_ff - 16'd1;

   always_comb begin
      res       = '0;
      phase_in  = phase_ff;
      count_in  = count_ff;
      remain_in = remain_ff;
      hist_in   = hist_ff;
      unique case (phase_ff)
         PH_PAYLOAD: begin
            res.valid        = 1'b1;
            res.kind         = KIND_PAYLOAD;
            res.payload_byte = stream_byte;
            res.last         = (remain_dec == 16'd0);
            remain_in        = remain_dec;
            if (remain_dec == 16'd0) begin
               phase_in = PH_HEADER;
            end
         end
         PH_HEADER: begin
            hist_in = full[HIST_W-1:0];
            if (count_ff != LAST_IDX) begin
               count_in = count_ff + 1'b1;
            end else begin
               count_in  = '0;
               res.valid = 1'b1;
               res.last  = 1'b1;
               if (magic != cfg.magic) begin
                  res.kind       = KIND_ERROR;
                  res.error_kind = ERR_MAGIC;
                  phase_in       = PH_DEAD;
               end else if (version != cfg.version) begin
                  res.kind       = KIND_ERROR;
                  res.error_kind = ERR_VERSION;
                  phase_in       = PH_DEAD;
               end else if (total < HDR_LEN) begin
                  res.kind       = KIND_ERROR;
                  res.error_kind = ERR_LENGTH;
                  phase_in       = PH_DEAD;
               end else begin
                  res.kind           = KIND_HEADER;
                  res.message_type   = full[71:64];
                  res.status_code    = full[47:32];
                  res.sequence_res   = full[31:0];
                  res.payload_length = total - HDR_LEN;
                  res.last           = (total == HDR_LEN);
                  remain_in          = total - HDR_LEN;
                  if (total != HDR_LEN) begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         count_ff  <= '0;
         remain_ff <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         remain_ff <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         hist_ff <= hist_in;
      end
   end

endmodule

// File: hdl/message_frame_deframer_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  stream_byte
// rsp_      out        rsp_valid/rsp_stall  kind .. error_kind
// csr       in/out     psel/penable/pready  expected_magic @0, expected_version @4
//
// One byte per cycle sustained while rsp_stall is low; a byte waits in the input
// register, and its result is computed and registered into the output register.
// Synchronous reset clears the framing state; after a frame error the block
// stays dead until reset. rsp_stall holds the output register and backs up
// into req_stall only while both registers are full.

module message_frame_deframer_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_stream_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_kind,
   output logic [7:0]                     rsp_message_type,
   output logic [15:0]                    rsp_status_code,
   output logic [31:0]                    rsp_sequence_res,
   output logic [15:0]                    rsp_payload_length,
   output logic [7:0]                     rsp_payload_byte,
   output logic                           rsp_last,
   output logic [1:0]                     rsp_error_kind,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [mfd_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [mfd_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [mfd_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import mfd_pkg::*;

   cfg_type cfg;
   rsp_type res;
   rsp_type rsp_ff;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       adv;
   logic       step;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && adv;
   assign req_stall = in_valid_ff && !adv;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = adv ? (step && res.valid) : rsp_valid_ff;

   mfd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mfd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .stream_byte (in_byte_ff),
      .cfg         (cfg),
      .res         (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_stream_byte;
      end
      if (step && res.valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_ff.kind;
   assign rsp_message_type   = rsp_ff.message_type;
   assign rsp_status_code    = rsp_ff.status_code;
   assign rsp_sequence_res   = rsp_ff.sequence_res;
   assign rsp_payload_length = rsp_ff.payload_length;
   assign rsp_payload_byte   = rsp_ff.payload_byte;
   assign rsp_last           = rsp_ff.last;
   assign rsp_error_kind     = rsp_ff.error_kind;

endmodule

// File: hdl/mfd_checker.sv
`timescale 1ns / 1ps
`include "message_frame_deframer_top_macros.svh"

module mfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_kind,
   input logic [15:0] rsp_payload_length,
   input logic        rsp_last
);
   import mfd_pkg::*;

   logic is_error;
   logic is_header;
   logic no_payload;

   assign is_error   = rsp_valid && (rsp_kind == KIND_ERROR);
   assign is_header  = rsp_valid && (rsp_kind == KIND_HEADER);
   assign no_payload = (rsp_payload_length == 16'd0);

   `MFD_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "result dropped while stalled")
   `MFD_ASSERT_IMP(a_no_stall_when_empty, !rsp_valid, !req_stall, "input stalled, output empty")
   `MFD_ASSERT_IMP(a_error_last, is_error, rsp_last && no_payload, "error result malformed")
   `MFD_ASSERT_IMP(a_header_last, is_header, rsp_last == no_payload, "header last flag mismatch")

endmodule

bind message_frame_deframer_top mfd_checker u_mfd_checker (.*);

// File: test/message_frame_deframer_top_tb.sv
`timescale 1ns / 1ps

module message_frame_deframer_top_tb;
   import mfd_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] ADDR_MAGIC   = {REG_MAGIC, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_VERSION = {REG_VERSION, 2'b00};
   localparam int RANDOM_PHASES = 4;
   localparam int BYTES_PER_PHASE = 45;

   typedef enum logic [1:0] {COLLECTING, IN_PAYLOAD, LINK_DEAD} rx_phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  message_type;
      logic [15:0] status_code;
      logic [31:0] sequence_res;
      logic [15:0] payload_length;
      logic [7:0]  payload_byte;
      logic        last;
      logic [1:0]  error_kind;
   } frame_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_stream_byte = 8'h00;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_kind;
   logic [7:0]            rsp_message_type;
   logic [15:0]           rsp_status_code;
   logic [31:0]           rsp_sequence_res;
   logic [15:0]           rsp_payload_length;
   logic [7:0]            rsp_payload_byte;
   logic                  rsp_last;
   logic [1:0]            rsp_error_kind;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // stream bytes waiting to be sent and results the deframer owes us
   logic [7:0]       pending_bytes[$];
   frame_result_type expected_results[$];
   int               fail_count = 0;

   // mirror of the deframer
   logic [15:0]  cfg_magic = 16'h0000;
   logic [7:0]   cfg_version = 8'h00;
   logic [7:0]   hdr[HDR_BYTES];
   logic [3:0]   hdr_count = '0;
   logic [15:0]  payload_left = '0;
   rx_phase_type rx_phase = COLLECTING;

   message_frame_deframer_top i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_stream_byte(req_stream_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_message_type(rsp_message_type),
      .rsp_status_code(rsp_status_code),
      .rsp_sequence_res(rsp_sequence_res),
      .rsp_payload_length(rsp_payload_length),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_last(rsp_last),
      .rsp_error_kind(rsp_error_kind),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   function automatic void deframe_byte(input logic [7:0] b);
      frame_result_type r;
      logic [15:0]      total;
      r = '0;
      case (rx_phase)
         IN_PAYLOAD: begin
            r.kind = KIND_PAYLOAD;
            r.payload_byte = b;
            payload_left = payload_left - 16'd1;
            if (payload_left == 16'd0) begin
               r.last = 1'b1;
               rx_phase = COLLECTING;
            end
            expected_results.push_back(r);
         end
         COLLECTING: begin
            hdr[hdr_count] = b;
            if (hdr_count != 4'(HDR_BYTES - 1)) begin
               hdr_count = hdr_count + 4'd1;
            end else begin
               hdr_count = '0;
               total = {hdr[4], hdr[5]};
               r.kind = KIND_ERROR;
               r.last = 1'b1;
               rx_phase = LINK_DEAD;
               if ({hdr[0], hdr[1]} != cfg_magic) begin
                  r.error_kind = ERR_MAGIC;
               end else if (hdr[2] != cfg_version) begin
                  r.error_kind = ERR_VERSION;
               end else if (total < 16'(HDR_BYTES)) begin
                  r.error_kind = ERR_LENGTH;
               end else begin
                  r.kind = KIND_HEADER;
                  r.message_type = hdr[3];
                  r.status_code = {hdr[6], hdr[7]};
                  r.sequence_res = {hdr[8], hdr[9], hdr[10], hdr[11]};
                  r.payload_length = total - 16'(HDR_BYTES);
                  payload_left = r.payload_length;
                  r.last = (payload_left == 16'd0);
                  rx_phase = r.last ? COLLECTING : IN_PAYLOAD;
               end
               expected_results.push_back(r);
            end
         end
         default: ;
      endcase
   endfunction

   // driver: bursts of random length separated by random, possibly empty, gaps
   always @(posedge clock) begin : driver
      static int burst_left = 1;
      static int gap_left = 0;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) deframe_byte(req_stream_byte);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               req_valid <= 1'b1;
               req_stream_byte <= pending_bytes.pop_front();
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                           : $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: compares each result transaction, stalls in modes of its own
   always @(posedge clock) begin : monitor
      static int stall_mode = 0;
      static int stall_left = 0;
      frame_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result transaction: kind 0x%0h", rsp_kind);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_kind));
               check_field("message_type", 32'(want.message_type), 32'(rsp_message_type));
               check_field("status_code", 32'(want.status_code), 32'(rsp_status_code));
               check_field("sequence_res", want.sequence_res, rsp_sequence_res);
               check_field("payload_length", 32'(want.payload_length),
                           32'(rsp_payload_length));
               check_field("payload_byte", 32'(want.payload_byte), 32'(rsp_payload_byte));
               check_field("last", 32'(want.last), 32'(rsp_last));
               check_field("error_kind", 32'(want.error_kind), 32'(rsp_error_kind));
            end
         end
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(1, 40);
         end else begin
            stall_left--;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= wr;
      paddr <= addr;
      pwdata <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_config(input logic [15:0] magic, input logic [7:0] version);
      logic [31:0] rd;
      csr_access(1'b1, ADDR_MAGIC, {16'h0000, magic}, rd);
      cfg_magic = magic;
      csr_access(1'b1, ADDR_VERSION, {24'h000000, version}, rd);
      cfg_version = version;
      csr_access(1'b0, ADDR_MAGIC, '0, rd);
      check_field("expected_magic readback", 32'(cfg_magic), 32'(rd[15:0]));
      csr_access(1'b0, ADDR_VERSION, '0, rd);
      check_field("expected_version readback", 32'(cfg_version), 32'(rd[7:0]));
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic void push_frame(input logic [15:0] magic, input logic [7:0] version,
                                      input logic [7:0] mtype, input logic [15:0] total,
                                      input logic [15:0] code, input logic [31:0] seq);
      pending_bytes.push_back(magic[15:8]);
      pending_bytes.push_back(magic[7:0]);
      pending_bytes.push_back(version);
      pending_bytes.push_back(mtype);
      pending_bytes.push_back(total[15:8]);
      pending_bytes.push_back(total[7:0]);
      pending_bytes.push_back(code[15:8]);
      pending_bytes.push_back(code[7:0]);
      pending_bytes.push_back(seq[31:24]);
      pending_bytes.push_back(seq[23:16]);
      pending_bytes.push_back(seq[15:8]);
      pending_bytes.push_back(seq[7:0]);
   endfunction

   function automatic void push_payload(input int count);
      repeat (count) pending_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 3))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   initial begin : stimulus
      int          sent;
      int          plen;
      logic [15:0] bad_magic;
      logic [7:0]  bad_version;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // registers at their reset values, header all zero but its length field, no payload
      push_frame(16'h0000, 8'h00, 8'h00, 16'd12, 16'h0000, 32'h0000_0000);
      wait_drained();

      set_config(16'hFFFF, 8'hFF);
      push_frame(16'hFFFF, 8'hFF, 8'hFF, 16'd12, 16'hFFFF, 32'hFFFF_FFFF);
      push_frame(16'hFFFF, 8'hFF, 8'h5A, 16'd16, 16'hA5C3, 32'h1234_5678);
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(8'hFF);
      pending_bytes.push_back(8'hA5);
      pending_bytes.push_back(8'h5A);
      push_frame(16'hFFFF, 8'hFF, 8'h01, 16'd13, 16'h0001, 32'h8000_0001);
      pending_bytes.push_back(8'h80);
      wait_drained();

      // length field with a nonzero upper byte
      set_config(16'hA55A, 8'h3C);
      push_frame(16'hA55A, 8'h3C, 8'hC3, 16'd264, 16'h5AA5, 32'hDEAD_BEEF);
      push_payload(264 - HDR_BYTES);
      wait_drained();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         set_config(pick16(), 8'(pick16()));
         sent = 0;
         while (sent < BYTES_PER_PHASE) begin
            case ($urandom_range(0, 19))
               0: plen = $urandom_range(41, 300);
               1, 2, 3, 4, 5: plen = $urandom_range(9, 40);
               default: plen = $urandom_range(0, 8);
            endcase
            push_frame(cfg_magic, cfg_version, 8'($urandom_range(0, 255)),
                       16'(HDR_BYTES + plen), 16'($urandom_range(0, 65535)), $urandom());
            push_payload(plen);
            sent += HDR_BYTES + plen;
         end
         wait_drained();
      end

      // one framing error ends the connection; later bytes are ignored
      bad_magic = cfg_magic ^ 16'($urandom_range(1, 65535));
      bad_version = cfg_version ^ 8'($urandom_range(1, 255));
      push_frame(cfg_magic, cfg_version, 8'h11, 16'd14, 16'h2222, 32'h3333_4444);
      push_payload(2);
      case ($urandom_range(0, 2))
         0: push_frame(bad_magic, 8'($urandom_range(0, 255)), 8'h00, 16'd20,
                       16'h0000, 32'h0);
         1: push_frame(cfg_magic, bad_version, 8'h00, 16'($urandom_range(0, 65535)),
                       16'h0000, 32'h0);
         default: push_frame(cfg_magic, cfg_version, 8'h00, 16'($urandom_range(0, 11)),
                             16'h0000, 32'h0);
      endcase
      push_frame(cfg_magic, cfg_version, 8'h00, 16'd12, 16'h0000, 32'h0);
      push_payload(20);
      wait_drained();
      repeat (20) @(posedge clock);

      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #1_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: message_frame_deframer_top.f
+incdir+hdl
hdl/mfd_pkg.sv
hdl/mfd_csr.sv
hdl/mfd_core.sv
hdl/message_frame_deframer_top.sv
hdl/mfd_checker.sv
test/message_frame_deframer_top_tb.sv
